FILE: rtl/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Types, codes and keymap tables for the two-set hangul syllable composer.
// ----------------------------------------------------------------------------
package hts_pkg;

  // request codes
  localparam logic [1:0] REQ_KEY    = 2'd0;
  localparam logic [1:0] REQ_FLUSH  = 2'd1;
  localparam logic [1:0] REQ_TOGGLE = 2'd2;

  // result status codes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_CODE = 2'd1;
  localparam logic [1:0] ST_PASS = 2'd2;

  // keymap entry type field
  localparam logic [1:0] KEY_NONE    = 2'd0;
  localparam logic [1:0] KEY_INITIAL = 2'd1;
  localparam logic [1:0] KEY_MEDIAL  = 2'd2;

  // code point constants
  localparam logic [15:0] SYL_BASE    = 16'hAC00;
  localparam logic [15:0] VOWEL_BASE  = 16'h314F;
  localparam logic [4:0]  VOWEL_LAST  = 5'd20;
  localparam logic [9:0]  MEDIAL_CNT  = 10'd21;
  localparam logic [15:0] FINAL_CNT   = 16'd28;
  localparam logic [7:0]  SCAN_LIMIT  = 8'h40;

  // one input word
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] scan_code;
    logic       shift_held;
  } req_t;

  // one result word
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] code_point;
    logic        korean_mode;
    logic        last_of_run;
  } rsp_t;

  // decoded operation passed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PASS,
    OP_INIT,
    OP_MED,
    OP_COMMIT,
    OP_CLEAR
  } op_kind_e;

  typedef struct packed {
    op_kind_e   kind;
    logic [4:0] idx;
    logic       mode;
  } op_t;

  // two-set keymap: {type, 6-bit index}
  function automatic logic [7:0] key_code(input logic [5:0] sc, input logic sh);
    logic [7:0] c;
    begin
      case (sc)
        6'd16: c = sh ? 8'h48 : 8'h47;
        6'd17: c = sh ? 8'h4D : 8'h4C;
        6'd18: c = sh ? 8'h44 : 8'h43;
        6'd19: c = sh ? 8'h41 : 8'h40;
        6'd20: c = sh ? 8'h4A : 8'h49;
        6'd21: c = 8'h8C;
        6'd22: c = 8'h86;
        6'd23: c = 8'h82;
        6'd24: c = sh ? 8'h83 : 8'h81;
        6'd25: c = sh ? 8'h87 : 8'h85;
        6'd30: c = 8'h46;
        6'd31: c = 8'h42;
        6'd32: c = 8'h4B;
        6'd33: c = 8'h45;
        6'd34: c = 8'h52;
        6'd35: c = 8'h88;
        6'd36: c = 8'h84;
        6'd37: c = 8'h80;
        6'd38: c = 8'h94;
        6'd44: c = 8'h4F;
        6'd45: c = 8'h50;
        6'd46: c = 8'h4E;
        6'd47: c = 8'h51;
        6'd48: c = 8'h91;
        6'd49: c = 8'h8D;
        6'd50: c = 8'h92;
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  // initial index to final index, zero when it cannot close a syllable
  function automatic logic [4:0] initial_as_final(input logic [4:0] i);
    logic [4:0] f;
    begin
      case (i)
        5'd0:  f = 5'd1;
        5'd1:  f = 5'd2;
        5'd2:  f = 5'd4;
        5'd3:  f = 5'd7;
        5'd5:  f = 5'd8;
        5'd6:  f = 5'd16;
        5'd7:  f = 5'd17;
        5'd9:  f = 5'd19;
        5'd10: f = 5'd20;
        5'd11: f = 5'd21;
        5'd12: f = 5'd22;
        5'd14: f = 5'd23;
        5'd15: f = 5'd24;
        5'd16: f = 5'd25;
        5'd17: f = 5'd26;
        5'd18: f = 5'd27;
        default: f = 5'd0;
      endcase
      return f;
    end
  endfunction

  // final index back to the initial it moves on as
  function automatic logic [4:0] final_as_initial(input logic [4:0] f);
    logic [4:0] i;
    begin
      case (f)
        5'd1:  i = 5'd0;
        5'd2:  i = 5'd1;
        5'd4:  i = 5'd2;
        5'd7:  i = 5'd3;
        5'd8:  i = 5'd5;
        5'd16: i = 5'd6;
        5'd17: i = 5'd7;
        5'd19: i = 5'd9;
        5'd20: i = 5'd10;
        5'd21: i = 5'd11;
        5'd22: i = 5'd12;
        5'd23: i = 5'd14;
        5'd24: i = 5'd15;
        5'd25: i = 5'd16;
        5'd26: i = 5'd17;
        5'd27: i = 5'd18;
        default: i = 5'd0;
      endcase
      return i;
    end
  endfunction

  // compatibility jamo of a lone initial
  function automatic logic [15:0] initial_compat(input logic [4:0] i);
    logic [15:0] c;
    begin
      case (i)
        5'd0:  c = 16'h3131;
        5'd1:  c = 16'h3132;
        5'd2:  c = 16'h3134;
        5'd3:  c = 16'h3137;
        5'd4:  c = 16'h3138;
        5'd5:  c = 16'h3139;
        5'd6:  c = 16'h3141;
        5'd7:  c = 16'h3142;
        5'd8:  c = 16'h3143;
        5'd9:  c = 16'h3145;
        5'd10: c = 16'h3146;
        5'd11: c = 16'h3147;
        5'd12: c = 16'h3148;
        5'd13: c = 16'h3149;
        5'd14: c = 16'h314A;
        5'd15: c = 16'h314B;
        5'd16: c = 16'h314C;
        5'd17: c = 16'h314D;
        5'd18: c = 16'h314E;
        default: c = 16'h0000;
      endcase
      return c;
    end
  endfunction

  // compatibility jamo of a lone medial
  function automatic logic [15:0] lone_vowel(input logic [4:0] m);
    begin
      return (m <= VOWEL_LAST) ? (VOWEL_BASE + 16'(m)) : 16'h0000;
    end
  endfunction

endpackage

FILE: rtl/hts_front.sv
// ----------------------------------------------------------------------------
// hts_front
// Accepts request words, tracks the korean mode and decodes each word into
// an operation for the composing back end.
// ----------------------------------------------------------------------------
module hts_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hts_pkg::req_t item_i,
  input  logic          queue_full_i,
  output logic          op_push_o,
  output hts_pkg::op_t  op_o
);
  import hts_pkg::*;

  logic       mode_q, mode_d;
  logic [7:0] code;
  logic       take;

  assign take      = push_i && !queue_full_i;
  assign op_push_o = take;
  assign code      = key_code(item_i.scan_code[5:0], item_i.shift_held);

  // decode the request against the current mode
  always_comb begin
    mode_d    = mode_q;
    op_o.kind = OP_NOP;
    op_o.idx  = code[4:0];
    case (item_i.req_type)
      REQ_KEY: begin
        if (!mode_q) begin
          op_o.kind = OP_PASS;
        end else if (item_i.scan_code < SCAN_LIMIT) begin
          case (code[7:6])
            KEY_INITIAL: op_o.kind = OP_INIT;
            KEY_MEDIAL:  op_o.kind = OP_MED;
            default:     op_o.kind = OP_COMMIT;
          endcase
        end
      end
      REQ_FLUSH: op_o.kind = OP_COMMIT;
      REQ_TOGGLE: begin
        mode_d = !mode_q;
        // switching off drops the pending syllable
        if (mode_q) op_o.kind = OP_CLEAR;
      end
      default: op_o.kind = OP_NOP;
    endcase
    op_o.mode = mode_d;
  end

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (take) begin
      mode_q <= mode_d;
    end
  end

endmodule

FILE: rtl/hts_op_queue.sv
// ----------------------------------------------------------------------------
// hts_op_queue
// Two-entry queue of decoded operations between front and back end.
// ----------------------------------------------------------------------------
module hts_op_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  hts_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output hts_pkg::op_t op_o
);
  import hts_pkg::*;

  op_t        slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign op_o    = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= op_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: rtl/hts_back.sv
// ----------------------------------------------------------------------------
// hts_back
// Holds the partial syllable and, while the four-entry output queue has room
// for two words, takes one operation per cycle and writes one or two results.
// ----------------------------------------------------------------------------
module hts_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          op_empty_i,
  input  hts_pkg::op_t  op_i,
  output logic          op_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output hts_pkg::rsp_t result_o
);
  import hts_pkg::*;

  // syllable state
  logic [4:0] ini_q, ini_d, med_q, med_d, fin_q, fin_d;
  logic       ini_held_q, ini_held_d, med_held_q, med_held_d;

  // output queue
  rsp_t       buf_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q;

  logic        take, do_pop;
  logic [9:0]  pair;
  logic [15:0] syl_base;
  logic        cm_v;
  logic [15:0] cm_cp;
  logic [4:0]  as_final;
  logic        r0_v, r1_v;
  logic [1:0]  r0_st, r1_st;
  logic [15:0] r0_cp, r1_cp;
  rsp_t        w0, w1;

  assign take     = !op_empty_i && (cnt_q <= 3'd2);
  assign op_pop_o = take;
  assign do_pop   = pop_i && !empty_o;
  assign empty_o  = (cnt_q == 3'd0);
  assign result_o = buf_q[rd_q];

  // syllable code without final
  assign pair     = 10'(ini_q) * MEDIAL_CNT + 10'(med_q);
  assign syl_base = SYL_BASE + 16'(pair) * FINAL_CNT;
  assign as_final = initial_as_final(op_i.idx);

  // what a commit of the held jamo emits
  always_comb begin
    cm_v  = ini_held_q || med_held_q;
    cm_cp = 16'h0000;
    if (ini_held_q && med_held_q) cm_cp = syl_base + 16'(fin_q);
    else if (ini_held_q)          cm_cp = initial_compat(ini_q);
    else if (med_held_q)          cm_cp = lone_vowel(med_q);
  end

  // execute one operation
  always_comb begin
    ini_d      = ini_q;
    med_d      = med_q;
    fin_d      = fin_q;
    ini_held_d = ini_held_q;
    med_held_d = med_held_q;
    r0_v  = 1'b0;
    r0_st = ST_NONE;
    r0_cp = 16'h0000;
    r1_v  = 1'b0;
    r1_st = ST_CODE;
    r1_cp = 16'h0000;
    case (op_i.kind)
      OP_PASS: begin
        r0_v  = 1'b1;
        r0_st = ST_PASS;
      end
      OP_COMMIT, OP_CLEAR: begin
        if (op_i.kind == OP_COMMIT && cm_v) begin
          r0_v  = 1'b1;
          r0_st = ST_CODE;
          r0_cp = cm_cp;
        end
        ini_d = '0; med_d = '0; fin_d = '0;
        ini_held_d = 1'b0; med_held_d = 1'b0;
      end
      OP_INIT: begin
        if (ini_held_q && med_held_q && fin_q == 5'd0 && as_final != 5'd0) begin
          fin_d = as_final;
        end else begin
          r0_v  = cm_v;
          r0_st = ST_CODE;
          r0_cp = cm_cp;
          ini_d = op_i.idx; med_d = '0; fin_d = '0;
          ini_held_d = 1'b1; med_held_d = 1'b0;
        end
      end
      OP_MED: begin
        if (ini_held_q && !med_held_q) begin
          med_d      = op_i.idx;
          med_held_d = 1'b1;
        end else if (ini_held_q && fin_q != 5'd0) begin
          // final moves on as the next initial
          r0_v  = 1'b1;
          r0_st = ST_CODE;
          r0_cp = syl_base;
          ini_d = final_as_initial(fin_q);
          med_d = op_i.idx;
          fin_d = '0;
          ini_held_d = 1'b1; med_held_d = 1'b1;
        end else begin
          // commit, then the vowel on its own
          if (cm_v) begin
            r0_v  = 1'b1;
            r0_st = ST_CODE;
            r0_cp = cm_cp;
            r1_v  = 1'b1;
            r1_cp = lone_vowel(op_i.idx);
          end else begin
            r0_v  = 1'b1;
            r0_st = ST_CODE;
            r0_cp = lone_vowel(op_i.idx);
          end
          ini_d = '0; med_d = '0; fin_d = '0;
          ini_held_d = 1'b0; med_held_d = 1'b0;
        end
      end
      default: begin
        r0_v = 1'b0;
      end
    endcase
    // a step with nothing emitted still gives one empty word
    if (!r0_v) begin
      r0_st = ST_NONE;
      r0_cp = 16'h0000;
    end
    w0.status      = r0_st;
    w0.code_point  = r0_cp;
    w0.korean_mode = op_i.mode;
    w0.last_of_run = !r1_v;
    w1.status      = r1_st;
    w1.code_point  = r1_cp;
    w1.korean_mode = op_i.mode;
    w1.last_of_run = 1'b1;
  end

  // syllable state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ini_q      <= '0;
      med_q      <= '0;
      fin_q      <= '0;
      ini_held_q <= 1'b0;
      med_held_q <= 1'b0;
    end else if (take) begin
      ini_q      <= ini_d;
      med_q      <= med_d;
      fin_q      <= fin_d;
      ini_held_q <= ini_held_d;
      med_held_q <= med_held_d;
    end
  end

  // output queue storage, up to two words written per cycle
  always_ff @(posedge clk_i) begin
    if (take) begin
      buf_q[wr_q] <= w0;
      if (r1_v) buf_q[wr_q + 2'd1] <= w1;
    end
  end

  // output queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (take)   wr_q <= wr_q + 2'd1 + 2'(r1_v);
      if (do_pop) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_q + (take ? (3'd1 + 3'(r1_v)) : 3'd0) - 3'(do_pop);
    end
  end

endmodule

FILE: rtl/hangul_two_set_composer.sv
// ----------------------------------------------------------------------------
// hangul_two_set_composer
// Two-set hangul composer: scancode words in, syllable and jamo code points
// out.
//
//   side    handshake        payload      notes
//   input   push_i / full_o  item_i       request type, scan code, shift
//   output  pop_i / empty_o  result_o     status, code point, mode, last
//
// A word accepted by the front end is decoded into the op queue; the back end
// executes it when the output queue has room and queues its results for result_o.
// The back end takes one word per cycle while the output queue has room for
// two results; a word that yields two results needs two pops to drain.
// Reset clears the mode, the held syllable and both queues.
// ----------------------------------------------------------------------------
module hangul_two_set_composer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hts_pkg::req_t item_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output hts_pkg::rsp_t result_o
);
  import hts_pkg::*;

  logic op_push, op_pop, op_empty;
  op_t  op_in, op_out;

  // decode and mode tracking
  hts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .item_i       (item_i),
    .queue_full_i (full_o),
    .op_push_o    (op_push),
    .op_o         (op_in)
  );

  // decoupling queue
  hts_op_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_push),
    .op_i    (op_in),
    .full_o  (full_o),
    .pop_i   (op_pop),
    .empty_o (op_empty),
    .op_o    (op_out)
  );

  // composition and output queue
  hts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_empty_i (op_empty),
    .op_i       (op_out),
    .op_pop_o   (op_pop),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .result_o   (result_o)
  );

endmodule

FILE: rtl/hts_checker.sv
// ----------------------------------------------------------------------------
// hts_port_assert
// Port-level checks of the composer's result stream.
// ----------------------------------------------------------------------------
module hts_port_assert (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          empty_o,
  input logic          pop_i,
  input hts_pkg::rsp_t result_o
);
  import hts_pkg::*;

  // a waiting word holds until popped
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(result_o)))
    else $error("result word changed while waiting");

  // code point is zero unless one was emitted
  a_cp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_o.status != ST_CODE) |-> (result_o.code_point == 16'h0000))
    else $error("code point set without emission");

  // passthrough only while composition is off
  a_pass_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_o.status == ST_PASS) |-> !result_o.korean_mode)
    else $error("passthrough reported in korean mode");

  // an empty result always stands alone
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && result_o.status == ST_NONE) |-> result_o.last_of_run)
    else $error("empty result not last of run");

endmodule

bind hangul_two_set_composer hts_port_assert u_hts_port_assert (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .empty_o  (empty_o),
  .pop_i    (pop_i),
  .result_o (result_o)
);

FILE: sim/hts_checker.sv
// ----------------------------------------------------------------------------
// hts_checker
// Watches both queue ports of the hangul composer. Each accepted request word
// is run through a local composer that predicts its result words. Each
// popped result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module hts_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          full_i,
  input  hts_pkg::req_t item_i,
  input  logic          pop_i,
  input  logic          empty_i,
  input  hts_pkg::rsp_t result_i,
  output int            outstanding_o,
  output int            errors_o
);

  import hts_pkg::*;

  // composer state: mode and the syllable being built
  logic       mode_on;
  logic [4:0] lead_idx;
  logic       lead_held;
  logic [4:0] vowel_idx;
  logic       vowel_held;
  logic [4:0] tail_idx;

  rsp_t step_words[$];
  rsp_t composed_q[$];
  int   mismatches = 0;

  // two-set keymap entry: {kind, index}, shift only changes a few keys
  function automatic logic [7:0] keymap_entry(input logic [5:0] sc, input logic sh);
    logic [7:0] e;
    case (sc)
      6'h10: e = 8'h47;
      6'h11: e = 8'h4C;
      6'h12: e = 8'h43;
      6'h13: e = 8'h40;
      6'h14: e = 8'h49;
      6'h15: e = 8'h8C;
      6'h16: e = 8'h86;
      6'h17: e = 8'h82;
      6'h18: e = 8'h81;
      6'h19: e = 8'h85;
      6'h1E: e = 8'h46;
      6'h1F: e = 8'h42;
      6'h20: e = 8'h4B;
      6'h21: e = 8'h45;
      6'h22: e = 8'h52;
      6'h23: e = 8'h88;
      6'h24: e = 8'h84;
      6'h25: e = 8'h80;
      6'h26: e = 8'h94;
      6'h2C: e = 8'h4F;
      6'h2D: e = 8'h50;
      6'h2E: e = 8'h4E;
      6'h2F: e = 8'h51;
      6'h30: e = 8'h91;
      6'h31: e = 8'h8D;
      6'h32: e = 8'h92;
      default: e = 8'h00;
    endcase
    // shifted keys give the tense consonant or the next vowel
    if (sh) begin
      case (sc)
        6'h10, 6'h11, 6'h12, 6'h13, 6'h14: e = e + 8'd1;
        6'h18, 6'h19: e = e + 8'd2;
        default: ;
      endcase
    end
    return e;
  endfunction

  // tail index that a lead consonant takes, zero when it cannot close
  function automatic logic [4:0] tail_of_lead(input logic [4:0] i);
    case (i)
      5'd0:  return 5'd1;
      5'd1:  return 5'd2;
      5'd2:  return 5'd4;
      5'd3:  return 5'd7;
      5'd5:  return 5'd8;
      5'd6:  return 5'd16;
      5'd7:  return 5'd17;
      5'd9:  return 5'd19;
      5'd10: return 5'd20;
      5'd11: return 5'd21;
      5'd12: return 5'd22;
      5'd14: return 5'd23;
      5'd15: return 5'd24;
      5'd16: return 5'd25;
      5'd17: return 5'd26;
      5'd18: return 5'd27;
      default: return 5'd0;
    endcase
  endfunction

  // compatibility jamo of a lone lead consonant, as offset from 0x3131
  function automatic logic [15:0] lead_jamo(input logic [4:0] i);
    logic [7:0] ofs;
    case (i)
      5'd0:  ofs = 8'd0;
      5'd1:  ofs = 8'd1;
      5'd2:  ofs = 8'd3;
      5'd3:  ofs = 8'd6;
      5'd4:  ofs = 8'd7;
      5'd5:  ofs = 8'd8;
      5'd6:  ofs = 8'd16;
      5'd7:  ofs = 8'd17;
      5'd8:  ofs = 8'd18;
      5'd9:  ofs = 8'd20;
      5'd10: ofs = 8'd21;
      5'd11: ofs = 8'd22;
      5'd12: ofs = 8'd23;
      5'd13: ofs = 8'd24;
      5'd14: ofs = 8'd25;
      5'd15: ofs = 8'd26;
      5'd16: ofs = 8'd27;
      5'd17: ofs = 8'd28;
      5'd18: ofs = 8'd29;
      default: return 16'h0000;
    endcase
    return 16'h3131 + 16'(ofs);
  endfunction

  function automatic logic [15:0] vowel_jamo(input logic [4:0] m);
    return (m <= 5'd20) ? 16'h314F + 16'(m) : 16'h0000;
  endfunction

  function automatic logic [15:0] syllable_code(input logic [4:0] tail);
    int cp;
    cp = 'hAC00 + (int'(lead_idx) * 21 + int'(vowel_idx)) * 28 + int'(tail);
    return cp[15:0];
  endfunction

  // at most two words per request
  function automatic void emit(input logic [1:0] st, input logic [15:0] cp);
    rsp_t r;
    r = '0;
    r.status = st;
    r.code_point = cp;
    if (step_words.size() < 2) step_words.push_back(r);
  endfunction

  function automatic void clear_syllable();
    lead_idx = '0;
    lead_held = 1'b0;
    vowel_idx = '0;
    vowel_held = 1'b0;
    tail_idx = '0;
  endfunction

  // hand out whatever is held, then start over
  function automatic void commit_syllable();
    if (lead_held && vowel_held) emit(ST_CODE, syllable_code(tail_idx));
    else if (lead_held) emit(ST_CODE, lead_jamo(lead_idx));
    else if (vowel_held) emit(ST_CODE, vowel_jamo(vowel_idx));
    clear_syllable();
  endfunction

  function automatic void start_lead(input logic [4:0] i);
    clear_syllable();
    lead_idx = i;
    lead_held = 1'b1;
  endfunction

  // consonant key: close an open syllable or begin a new one
  function automatic void press_consonant(input logic [4:0] i);
    logic [4:0] t;
    t = tail_of_lead(i);
    if (lead_held && vowel_held && tail_idx == 5'd0 && t != 5'd0) begin
      tail_idx = t;
    end else begin
      commit_syllable();
      start_lead(i);
    end
  endfunction

  // vowel key: attach, steal the tail for a new syllable, or stand alone
  function automatic void press_vowel(input logic [4:0] m);
    logic [4:0] moved;
    logic       found;
    if (lead_held && !vowel_held) begin
      vowel_idx = m;
      vowel_held = 1'b1;
    end else if (lead_held && tail_idx != 5'd0) begin
      moved = 5'd0;
      found = 1'b0;
      emit(ST_CODE, syllable_code(5'd0));
      for (int j = 0; j < 19; j++) begin
        if (!found && tail_of_lead(5'(j)) == tail_idx) begin
          moved = 5'(j);
          found = 1'b1;
        end
      end
      start_lead(moved);
      vowel_idx = m;
      vowel_held = 1'b1;
    end else begin
      commit_syllable();
      emit(ST_CODE, vowel_jamo(m));
    end
  endfunction

  // one request word in, its result words onto the expected queue
  function automatic void compose_step(input req_t w);
    logic [7:0] ent;
    rsp_t       r;
    step_words.delete();
    case (w.req_type)
      REQ_KEY: begin
        if (!mode_on) begin
          emit(ST_PASS, 16'h0000);
        end else if (w.scan_code < SCAN_LIMIT) begin
          ent = keymap_entry(w.scan_code[5:0], w.shift_held);
          if (ent[7:6] == KEY_INITIAL) press_consonant(ent[4:0]);
          else if (ent[7:6] == KEY_MEDIAL) press_vowel(ent[4:0]);
          else commit_syllable();
        end
      end
      REQ_FLUSH: commit_syllable();
      REQ_TOGGLE: begin
        mode_on = !mode_on;
        if (!mode_on) clear_syllable();
      end
      default: ;
    endcase
    if (step_words.size() == 0) emit(ST_NONE, 16'h0000);
    for (int k = 0; k < step_words.size(); k++) begin
      r = step_words[k];
      r.korean_mode = mode_on;
      r.last_of_run = (k == step_words.size() - 1);
      composed_q.push_back(r);
    end
  endfunction

  // compare a popped word with the oldest prediction
  function automatic void check_result(input rsp_t got);
    rsp_t want;
    logic bad;
    if (composed_q.size() == 0) begin
      $error("result word with nothing expected: status %0d code_point %h",
             got.status, got.code_point);
      mismatches++;
    end else begin
      want = composed_q.pop_front();
      bad = 1'b0;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        bad = 1'b1;
      end
      if (got.code_point !== want.code_point) begin
        $error("code_point: expected %h, got %h", want.code_point, got.code_point);
        bad = 1'b1;
      end
      if (got.korean_mode !== want.korean_mode) begin
        $error("korean_mode: expected %0d, got %0d", want.korean_mode, got.korean_mode);
        bad = 1'b1;
      end
      if (got.last_of_run !== want.last_of_run) begin
        $error("last_of_run: expected %0d, got %0d", want.last_of_run, got.last_of_run);
        bad = 1'b1;
      end
      if (bad) mismatches++;
    end
  endfunction

  // sample both handshakes at the edge, pop side first
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mode_on = 1'b0;
      clear_syllable();
      composed_q.delete();
    end else begin
      if (pop_i && !empty_i) check_result(result_i);
      if (push_i && !full_i) compose_step(item_i);
    end
    outstanding_o <= composed_q.size();
    errors_o <= mismatches;
  end

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives request words into the hangul composer: a directed run through the
// keymap corner cases, then random key sequences with flushes, mode toggles
// and junk words. The receiver stalls at random and once for a long stretch.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb;

  import hts_pkg::*;

  localparam int         RESET_CYCLES = 11;
  localparam int         RANDOM_WORDS = 850;
  localparam int         HOLD_START   = 300;
  localparam int         PAUSE_AT     = 500;
  localparam int         STEADY_FROM  = 600;
  localparam int         STEADY_TO    = 750;
  localparam int         HOLD_CYCLES  = 300;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam logic [1:0] REQ_UNUSED   = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push_i = 1'b0;
  logic pop_i = 1'b0;
  req_t item_i = '0;
  logic full_o;
  logic empty_o;
  rsp_t result_o;

  int   outstanding;
  int   errors;
  int   cycle_cnt = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic hold_req = 1'b0;
  logic steady = 1'b0;
  logic korean_on = 1'b0;
  req_t script[$];

  always #4 clk_i = ~clk_i;

  hangul_two_set_composer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .item_i  (item_i),
    .full_o  (full_o),
    .empty_o (empty_o),
    .pop_i   (pop_i),
    .result_o(result_o)
  );

  hts_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_i),
    .full_i       (full_o),
    .item_i       (item_i),
    .pop_i        (pop_i),
    .empty_i      (empty_o),
    .result_i     (result_o),
    .outstanding_o(outstanding),
    .errors_o     (errors)
  );

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else if (hold_left > 0) begin
      pop_i <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      pop_i <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      pop_i <= steady || ($urandom_range(99) >= 6);
    end
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb failed");
    $finish;
  end

  function automatic req_t make_word(input logic [1:0] r, input logic [7:0] sc,
                                     input logic sh);
    req_t w;
    w.req_type = r;
    w.scan_code = sc;
    w.shift_held = sh;
    return w;
  endfunction

  // mostly jamo keys while korean mode is on, toggles to get back into it
  function automatic req_t random_word();
    req_t w;
    int   pick;
    w = make_word(REQ_KEY, 8'($urandom_range(16, 50)), 1'($urandom_range(1)));
    pick = $urandom_range(99);
    if (!korean_on) begin
      if (pick < 30) w.req_type = REQ_TOGGLE;
      else if (pick < 40) w.req_type = REQ_FLUSH;
      else if (pick < 45) w.req_type = REQ_UNUSED;
      else if (pick < 55) w.scan_code = 8'($urandom_range(255));
    end else begin
      if (pick < 2) w.req_type = REQ_TOGGLE;
      else if (pick < 8) w.req_type = REQ_FLUSH;
      else if (pick < 10) w.req_type = REQ_UNUSED;
      else if (pick < 18) w.scan_code = 8'($urandom_range(255));
    end
    return w;
  endfunction

  // offer one word and hold it until accepted
  task automatic send_word(input req_t w);
    item_i <= w;
    push_i <= 1'b1;
    do @(posedge clk_i); while (full_o);
    if (w.req_type == REQ_TOGGLE) korean_on = !korean_on;
  endtask

  // one idle cycle now and then
  task automatic maybe_idle();
    if (!steady && $urandom_range(99) < 6) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    push_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: inactive mode, junk words, then the composition corner cases
    script.push_back(make_word(REQ_KEY, 8'h10, 1'b0));    // passthrough
    script.push_back(make_word(REQ_FLUSH, 8'h00, 1'b0));  // nothing held, inactive
    script.push_back(make_word(REQ_UNUSED, 8'hFF, 1'b1));
    script.push_back(make_word(REQ_TOGGLE, 8'h00, 1'b0));
    script.push_back(make_word(REQ_KEY, 8'hFF, 1'b1));    // out of keymap range
    script.push_back(make_word(REQ_KEY, 8'h40, 1'b0));
    script.push_back(make_word(REQ_KEY, 8'h13, 1'b0));    // lead
    script.push_back(make_word(REQ_KEY, 8'h23, 1'b0));    // vowel
    script.push_back(make_word(REQ_KEY, 8'h10, 1'b0));    // tail
    script.push_back(make_word(REQ_KEY, 8'h25, 1'b0));    // tail moves on
    script.push_back(make_word(REQ_KEY, 8'h24, 1'b0));    // vowel after open syllable
    script.push_back(make_word(REQ_KEY, 8'h12, 1'b0));
    script.push_back(make_word(REQ_KEY, 8'h26, 1'b0));
    script.push_back(make_word(REQ_KEY, 8'h10, 1'b1));    // double b cannot close
    script.push_back(make_word(REQ_FLUSH, 8'h00, 1'b0));  // lone lead
    script.push_back(make_word(REQ_KEY, 8'h32, 1'b0));    // lone vowel
    script.push_back(make_word(REQ_KEY, 8'h2C, 1'b0));
    script.push_back(make_word(REQ_KEY, 8'h1C, 1'b0));    // non-jamo key commits
    script.push_back(make_word(REQ_KEY, 8'h22, 1'b0));
    script.push_back(make_word(REQ_KEY, 8'h18, 1'b1));
    script.push_back(make_word(REQ_KEY, 8'h11, 1'b1));    // double j cannot close
    script.push_back(make_word(REQ_KEY, 8'h19, 1'b1));
    script.push_back(make_word(REQ_KEY, 8'h22, 1'b0));    // highest tail
    script.push_back(make_word(REQ_KEY, 8'h3F, 1'b1));    // commit full syllable
    script.push_back(make_word(REQ_KEY, 8'h11, 1'b0));
    script.push_back(make_word(REQ_TOGGLE, 8'h00, 1'b0)); // off drops the lead
    foreach (script[k]) begin
      send_word(script[k]);
      maybe_idle();
    end

    // random words with one receiver hold-off, one pause and a steady stretch
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == HOLD_START) hold_req <= 1'b1;
      if (n == PAUSE_AT) wait_drained();
      steady <= (n >= STEADY_FROM && n < STEADY_TO);
      send_word(random_word());
      maybe_idle();
    end

    // drain and let any stray word show up
    steady <= 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
